// ----- src/bbq_pkg.sv -----
// ----------------------------------------------------------------------------
// bbq_pkg
// types, constants and helper functions of the billboard quad expander
// ----------------------------------------------------------------------------
`default_nettype none

package bbq_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned CORDIC_MAX        = 24;
  localparam int unsigned CW                = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_RIGHT_X = 3'd0,
    REG_RIGHT_Y = 3'd1,
    REG_RIGHT_Z = 3'd2,
    REG_UP_X    = 3'd3,
    REG_UP_Y    = 3'd4,
    REG_UP_Z    = 3'd5
  } bbq_reg_e;

  typedef enum logic [1:0] {
    CORNER_LL = 2'd0,
    CORNER_LR = 2'd1,
    CORNER_UR = 2'd2,
    CORNER_UL = 2'd3
  } bbq_corner_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        spin;
    logic [30:0]        width;
    logic [30:0]        height;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [15:0]        alpha;
  } bbq_in_t;

  typedef struct packed {
    logic [1:0]         corner;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic [31:0]        packed_colour;
    logic               last_corner;
  } bbq_out_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [30:0]      width;
    logic [30:0]      height;
    logic [31:0]      colour;
  } bbq_side_t;

  function automatic logic signed [CW-1:0] atan_f(int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2FA;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      default: a = 32'h0;
    endcase
    return $signed({2'b00, a});
  endfunction

  function automatic logic [7:0] colour_byte(logic [15:0] c);
    logic [23:0] p;
    logic [8:0]  b;
    p = {8'h0, c} * 24'd255;
    b = p[23:15];
    return b[8] ? 8'hFF : b[7:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/bbq_if.sv -----
// ----------------------------------------------------------------------------
// bbq_in_if / bbq_out_if
// valid/ready channels carrying particles in and corner vertices out
// ----------------------------------------------------------------------------
`default_nettype none

interface bbq_in_if import bbq_pkg::*;;
  logic    valid;
  logic    ready;
  bbq_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bbq_out_if import bbq_pkg::*;;
  logic     valid;
  logic     ready;
  bbq_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/bbq_cordic.sv -----
// ----------------------------------------------------------------------------
// bbq_cordic
// pipelined cordic rotator, one iteration per register stage, with side data
// ----------------------------------------------------------------------------
`default_nettype none

module bbq_cordic import bbq_pkg::*; #(
  parameter int unsigned STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [15:0]          spin_i,
  input  wire bbq_side_t            side_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [CW-1:0]      x_o,
  output logic signed [CW-1:0]      y_o,
  output logic                      flip_o,
  output logic                      zero_o,
  output bbq_side_t                 side_o
);

  logic [STAGES:0]        vld_q;
  logic [STAGES:0]        en;
  logic signed [CW-1:0]   x_q [STAGES+1];
  logic signed [CW-1:0]   y_q [STAGES+1];
  logic signed [CW-1:0]   z_q [STAGES+1];
  logic [STAGES:0]        flip_q;
  logic [STAGES:0]        zero_q;
  bbq_side_t              side_q [STAGES+1];

  always_comb begin
    en[STAGES] = !vld_q[STAGES] || out_ready_i;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k <= STAGES; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_q[0]    <= CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= $signed({{3{spin_i[14]}}, spin_i[14:0], 16'h0000});
      flip_q[0] <= spin_i[15] ^ spin_i[14];
      zero_q[0] <= (spin_i == 16'h0000);
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_iter
    logic signed [CW-1:0] xs, ys;
    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;
    always_ff @(posedge clk_i) begin
      if (en[k+1]) begin
        if (!z_q[k][CW-1]) begin
          x_q[k+1] <= x_q[k] - ys;
          y_q[k+1] <= y_q[k] + xs;
          z_q[k+1] <= z_q[k] - atan_f(k);
        end else begin
          x_q[k+1] <= x_q[k] + ys;
          y_q[k+1] <= y_q[k] - xs;
          z_q[k+1] <= z_q[k] + atan_f(k);
        end
        flip_q[k+1] <= flip_q[k];
        zero_q[k+1] <= zero_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign out_valid_o = vld_q[STAGES];
  assign x_o         = x_q[STAGES];
  assign y_o         = y_q[STAGES];
  assign flip_o      = flip_q[STAGES];
  assign zero_o      = zero_q[STAGES];
  assign side_o      = side_q[STAGES];

  logic unused_z;
  assign unused_z = ^z_q[STAGES];

endmodule

`default_nettype wire

// ----- src/billboard_quad_expander.sv -----
// ----------------------------------------------------------------------------
// billboard_quad_expander
// expands one particle into the four corner vertices of a spinning billboard
//
//   channel  dir  transaction
//   in_i     in   one particle: centre, spin, size, colour
//   out_o    out  one corner vertex, four per particle, last one flagged
//   cfg_*    in   write of a view vector component, index 0..5
//
// the first corner leaves after the cordic stages and stages a to e; the output
// emits one corner per cycle while out_o is ready, four per particle, and new
// particles enter the pipeline while an earlier one is still going out.
// reset clears all valid bits and loads the default view vectors.
// a stall at the output holds every stage in place; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module billboard_quad_expander import bbq_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  bbq_in_if.sink                     in_i,
  bbq_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [15:0]           cfg_wdata_i
);

  logic [2:0][15:0] rv_q, uv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= {16'd0, 16'd0, 16'd16384};
      uv_q <= {16'd0, 16'd16384, 16'd0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RIGHT_X: rv_q[0] <= cfg_wdata_i;
        REG_RIGHT_Y: rv_q[1] <= cfg_wdata_i;
        REG_RIGHT_Z: rv_q[2] <= cfg_wdata_i;
        REG_UP_X:    uv_q[0] <= cfg_wdata_i;
        REG_UP_Y:    uv_q[1] <= cfg_wdata_i;
        REG_UP_Z:    uv_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bbq_side_t side_in;
  always_comb begin
    side_in.pos    = {in_i.data.pos_z, in_i.data.pos_y, in_i.data.pos_x};
    side_in.width  = in_i.data.width;
    side_in.height = in_i.data.height;
    side_in.colour = {colour_byte(in_i.data.alpha), colour_byte(in_i.data.blue),
                      colour_byte(in_i.data.green), colour_byte(in_i.data.red)};
  end

  logic                 cv, cready;
  logic signed [CW-1:0] cx, cy;
  logic                 cflip, czero;
  bbq_side_t            cside;

  bbq_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .spin_i      (in_i.data.spin),
    .side_i      (side_in),
    .out_valid_o (cv),
    .out_ready_i (cready),
    .x_o         (cx),
    .y_o         (cy),
    .flip_o      (cflip),
    .zero_o      (czero),
    .side_o      (cside)
  );

  logic va_q, vb_q, vc_q, vd_q, ve_q;
  logic ena, enb, enc, end_s, ene;
  logic [1:0] cnt_q;

  assign ene   = !ve_q || (out_o.ready && cnt_q == CORNER_UL);
  assign end_s = !vd_q || ene;
  assign enc   = !vc_q || end_s;
  assign enb   = !vb_q || enc;
  assign ena   = !va_q || enb;
  assign cready = ena;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
      vc_q  <= 1'b0;
      vd_q  <= 1'b0;
      ve_q  <= 1'b0;
      cnt_q <= CORNER_LL;
    end else begin
      if (ena)   va_q <= cv;
      if (enb)   vb_q <= va_q;
      if (enc)   vc_q <= vb_q;
      if (end_s) vd_q <= vc_q;
      if (ene)   ve_q <= vd_q;
      if (ve_q && out_o.ready) cnt_q <= cnt_q + 2'd1;
    end
  end

  // stage a: round, unfold and clamp cos / sin
  logic signed [CW-1:0] xr, yr;
  logic signed [18:0]   xc, yc;
  logic signed [15:0]   cos_d, sin_d, cos_q, sin_q;
  bbq_side_t            sa_q, sb_q, sc_q, sd_q, se_q;

  always_comb begin
    xr = (cx + 34'sd32768) >>> 16;
    yr = (cy + 34'sd32768) >>> 16;
    xc = cflip ? -xr[18:0] : xr[18:0];
    yc = cflip ? -yr[18:0] : yr[18:0];
    if (xc > 19'sd16384)       cos_d = 16'sd16384;
    else if (xc < -19'sd16384) cos_d = -16'sd16384;
    else                       cos_d = xc[15:0];
    if (yc > 19'sd16384)       sin_d = 16'sd16384;
    else if (yc < -19'sd16384) sin_d = -16'sd16384;
    else                       sin_d = yc[15:0];
    if (czero) begin
      cos_d = 16'sd16384;
      sin_d = 16'sd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ena) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
      sa_q  <= cside;
    end
  end

  // stage b: view vector products
  logic signed [31:0] rc_q [3], us_q [3], uc_q [3], rs_q [3];
  always_ff @(posedge clk_i) begin
    if (enb) begin
      for (int j = 0; j < 3; j++) begin
        rc_q[j] <= $signed(rv_q[j]) * cos_q;
        us_q[j] <= $signed(uv_q[j]) * sin_q;
        uc_q[j] <= $signed(uv_q[j]) * cos_q;
        rs_q[j] <= $signed(rv_q[j]) * sin_q;
      end
      sb_q <= sa_q;
    end
  end

  // stage c: rotated vectors
  logic signed [32:0] rot_r_q [3], rot_u_q [3];
  always_ff @(posedge clk_i) begin
    if (enc) begin
      for (int j = 0; j < 3; j++) begin
        rot_r_q[j] <= 33'(rc_q[j]) + 33'(us_q[j]);
        rot_u_q[j] <= 33'(uc_q[j]) - 33'(rs_q[j]);
      end
      sc_q <= sb_q;
    end
  end

  // stage d: scale by size
  logic signed [63:0] pr_q [3], pu_q [3];
  always_ff @(posedge clk_i) begin
    if (end_s) begin
      for (int j = 0; j < 3; j++) begin
        pr_q[j] <= 64'(rot_r_q[j] * $signed({1'b0, sc_q.width}));
        pu_q[j] <= 64'(rot_u_q[j] * $signed({1'b0, sc_q.height}));
      end
      sd_q <= sc_q;
    end
  end

  // stage e: rounded half offsets, held while the four corners go out
  logic signed [63:0] tr [3], tu [3];
  logic signed [34:0] off_r_q [3], off_u_q [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tr[j] = (pr_q[j] + 64'sd268435456) >>> 29;
      tu[j] = (pu_q[j] + 64'sd268435456) >>> 29;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ene) begin
      for (int j = 0; j < 3; j++) begin
        off_r_q[j] <= tr[j][34:0];
        off_u_q[j] <= tu[j][34:0];
      end
      se_q <= sd_q;
    end
  end

  logic               pos_r, pos_u;
  logic signed [36:0] vsum [3];
  logic signed [31:0] vsat [3];

  always_comb begin
    pos_r = (cnt_q == CORNER_LR) || (cnt_q == CORNER_UR);
    pos_u = cnt_q[1];
    for (int j = 0; j < 3; j++) begin
      vsum[j] = 37'($signed(se_q.pos[j]))
              + (pos_r ? 37'(off_r_q[j]) : -37'(off_r_q[j]))
              + (pos_u ? 37'(off_u_q[j]) : -37'(off_u_q[j]));
      if (vsum[j] > 37'sd2147483647)       vsat[j] = 32'sh7FFFFFFF;
      else if (vsum[j] < -37'sd2147483648) vsat[j] = 32'sh80000000;
      else                                 vsat[j] = vsum[j][31:0];
    end
  end

  assign out_o.valid              = ve_q;
  assign out_o.data.corner        = cnt_q;
  assign out_o.data.vert_x        = vsat[0];
  assign out_o.data.vert_y        = vsat[1];
  assign out_o.data.vert_z        = vsat[2];
  assign out_o.data.packed_colour = se_q.colour;
  assign out_o.data.last_corner   = (cnt_q == CORNER_UL);

endmodule

`default_nettype wire
